// ===== rtl/http_host_filter_match_core_defines.svh =====
// Assertion macros used by the host filter core.
`ifndef HTTP_HOST_FILTER_MATCH_CORE_DEFINES_SVH
`define HTTP_HOST_FILTER_MATCH_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define HHFM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define HHFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HHFM_ASSERT_SAME(label, ante, cons, msg)
`define HHFM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/hhfm_pkg.sv =====
// Types, constants and character tables for the host filter.
`default_nettype none

package hhfm_pkg;

    localparam int HOST_MAX_DEFAULT    = 32;
    localparam int MIN_PAYLOAD_DEFAULT = 50;

    localparam int PAT_BYTES  = 32;
    localparam int PAT_WORDS  = 4;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_W0 = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_W1 = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_W2 = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_W3 = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOST_LENGTH = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERT     = 8'd5;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_D  = 8'h44;
    localparam logic [7:0] CHAR_UP_E  = 8'h45;
    localparam logic [7:0] CHAR_UP_G  = 8'h47;
    localparam logic [7:0] CHAR_UP_H  = 8'h48;
    localparam logic [7:0] CHAR_UP_L  = 8'h4C;
    localparam logic [7:0] CHAR_UP_O  = 8'h4F;
    localparam logic [7:0] CHAR_UP_P  = 8'h50;
    localparam logic [7:0] CHAR_UP_S  = 8'h53;
    localparam logic [7:0] CHAR_UP_T  = 8'h54;
    localparam logic [7:0] CHAR_LO_O  = 8'h6F;
    localparam logic [7:0] CHAR_LO_S  = 8'h73;
    localparam logic [7:0] CHAR_LO_T  = 8'h74;

    localparam logic [2:0] HOST_TOKEN_LEN = 3'd6;

    typedef enum logic [2:0] {
        METHOD_WAIT = 3'd0,
        METHOD_GET  = 3'd1,
        METHOD_HEAD = 3'd2,
        METHOD_POST = 3'd3,
        METHOD_OK   = 3'd4,
        METHOD_FAIL = 3'd5
    } method_state_t;

    typedef enum logic [2:0] {
        REASON_SHORT     = 3'd0,
        REASON_NO_METHOD = 3'd1,
        REASON_NO_HOST   = 3'd2,
        REASON_HOST_MISS = 3'd3,
        REASON_HOST_HIT  = 3'd4,
        REASON_ALL       = 3'd5
    } reason_t;

    function automatic logic [7:0] host_token_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CHAR_UP_H;
            3'd1:    c = CHAR_LO_O;
            3'd2:    c = CHAR_LO_S;
            3'd3:    c = CHAR_LO_T;
            3'd4:    c = CHAR_COLON;
            3'd5:    c = CHAR_SPACE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [5:0] method_len(input method_state_t st);
        logic [5:0] n;
        case (st)
            METHOD_GET:  n = 6'd4;
            METHOD_HEAD: n = 6'd5;
            METHOD_POST: n = 6'd5;
            default:     n = 6'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] method_char(input method_state_t st, input logic [5:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (st)
            METHOD_GET:
            begin
                case (pos)
                    6'd0:    c = CHAR_UP_G;
                    6'd1:    c = CHAR_UP_E;
                    6'd2:    c = CHAR_UP_T;
                    6'd3:    c = CHAR_SPACE;
                    default: c = 8'h00;
                endcase
            end
            METHOD_HEAD:
            begin
                case (pos)
                    6'd0:    c = CHAR_UP_H;
                    6'd1:    c = CHAR_UP_E;
                    6'd2:    c = CHAR_UP_A;
                    6'd3:    c = CHAR_UP_D;
                    6'd4:    c = CHAR_SPACE;
                    default: c = 8'h00;
                endcase
            end
            METHOD_POST:
            begin
                case (pos)
                    6'd0:    c = CHAR_UP_P;
                    6'd1:    c = CHAR_UP_O;
                    6'd2:    c = CHAR_UP_S;
                    6'd3:    c = CHAR_UP_T;
                    6'd4:    c = CHAR_SPACE;
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/http_host_filter_match_core.sv =====
// Host filter core: one payload byte per transfer, one verdict per packet.
// After the last byte's transfer a verdict passes through stage one, stage two and the output register in turn.
// Throughput: one byte per cycle while s_tready is high; the window compare runs in parallel over all offsets.
// Input stalls only when the verdict pipeline is full and the output is held.
// Reset clears the configuration, the per-packet state and all pipeline valid flags.
`default_nettype none
`include "http_host_filter_match_core_defines.svh"

module http_host_filter_match_core
    import hhfm_pkg::*;
#(
    parameter int HOST_MAX    = HOST_MAX_DEFAULT,
    parameter int MIN_PAYLOAD = MIN_PAYLOAD_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] payload_byte
    input  wire logic                   s_tlast,   // last_byte
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [7:0]                  m_tdata,   // [0] verdict, [3:1] reason, [7:4] zero
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int WIN_IDX_W = (HOST_MAX > 1) ? $clog2(HOST_MAX) : 1;
    localparam int WLEN_W    = $clog2(HOST_MAX + 1);
    localparam logic [6:0] HOST_MAX_C    = 7'(HOST_MAX);
    localparam logic [5:0] MIN_PAYLOAD_C = 6'(MIN_PAYLOAD);

    logic [CFG_DATA_W-1:0] host_pattern_reg [PAT_WORDS];
    logic [5:0]            host_length_reg;
    logic                  invert_reg;

    method_state_t method_reg, method_next;
    logic          method_ok;
    logic [5:0]    byte_count_reg, byte_count_next;
    logic [2:0]    token_idx_reg, token_idx_next;
    logic          token_found_reg, token_found_next;
    logic          stopped_reg, stopped_next;
    logic [5:0]    bat_reg, bat_next;
    logic [7:0]    window_reg [HOST_MAX];
    logic [7:0]    window_next [HOST_MAX];
    logic          win_write;

    logic                s1_valid_reg, s1_valid_next;
    reason_t             s1_reason_reg, s1_reason_next;
    logic                s1_host_reg, s1_host_next;
    logic [7:0]          s1_window_reg [HOST_MAX];
    logic [WLEN_W-1:0]   s1_wlen_reg, s1_wlen_next;

    logic                s2_valid_reg, s2_valid_next;
    reason_t             s2_reason_reg, s2_reason_next;
    logic                s2_host_reg, s2_host_next;
    logic [HOST_MAX-1:0] s2_match_reg, s2_match_next;
    logic                s2_all_reg, s2_all_next;
    logic                s2_empty_reg, s2_empty_next;

    logic    out_valid_reg, out_valid_next;
    reason_t out_reason_reg, out_reason_next;
    logic    out_verdict_reg, out_verdict_next;

    logic out_free, s2_free, s1_free, s1_to_s2, s2_to_out;
    logic in_fire, last_fire;

    logic [7:0]          pat [PAT_BYTES];
    logic [PAT_BYTES-1:0] pat_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PAT_WORDS; k++)
            begin
                host_pattern_reg[k] <= '0;
            end
            host_length_reg <= '0;
            invert_reg      <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PATTERN_W0:  host_pattern_reg[0] <= cfg_data;
                CFG_PATTERN_W1:  host_pattern_reg[1] <= cfg_data;
                CFG_PATTERN_W2:  host_pattern_reg[2] <= cfg_data;
                CFG_PATTERN_W3:  host_pattern_reg[3] <= cfg_data;
                CFG_HOST_LENGTH: host_length_reg     <= cfg_data[5:0];
                CFG_INVERT:      invert_reg          <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign s1_to_s2  = s1_valid_reg && s2_free;
    assign s2_to_out = s2_valid_reg && out_free;
    assign s_tready  = s1_free;
    assign in_fire   = s_tvalid && s_tready;
    assign last_fire = in_fire && s_tlast;

    // Method recognizer: next state.
    always_comb
    begin
        method_next = method_reg;
        case (method_reg)
            METHOD_WAIT:
            begin
                if (s_tdata == CHAR_UP_G)
                begin
                    method_next = METHOD_GET;
                end
                else if (s_tdata == CHAR_UP_H)
                begin
                    method_next = METHOD_HEAD;
                end
                else if (s_tdata == CHAR_UP_P)
                begin
                    method_next = METHOD_POST;
                end
                else
                begin
                    method_next = METHOD_FAIL;
                end
            end
            METHOD_GET, METHOD_HEAD, METHOD_POST:
            begin
                if (byte_count_reg >= method_len(method_reg)
                    || s_tdata != method_char(method_reg, byte_count_reg))
                begin
                    method_next = METHOD_FAIL;
                end
                else if (byte_count_reg == method_len(method_reg) - 6'd1)
                begin
                    method_next = METHOD_OK;
                end
            end
            default: method_next = method_reg;
        endcase
    end

    // Method recognizer: output.
    always_comb
    begin
        case (method_next)
            METHOD_OK: method_ok = 1'b1;
            default:   method_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        token_idx_next   = token_idx_reg;
        token_found_next = token_found_reg;
        stopped_next     = stopped_reg;
        bat_next         = bat_reg;
        win_write        = 1'b0;
        if (token_found_reg)
        begin
            if (!stopped_reg)
            begin
                if (s_tdata == 8'h00)
                begin
                    stopped_next = 1'b1;
                end
                else if (bat_reg != 6'd63)
                begin
                    win_write = ({1'b0, bat_reg} < HOST_MAX_C);
                    bat_next  = bat_reg + 6'd1;
                end
            end
        end
        else if (token_idx_reg < HOST_TOKEN_LEN && s_tdata == host_token_char(token_idx_reg))
        begin
            token_idx_next   = token_idx_reg + 3'd1;
            token_found_next = (token_idx_reg == HOST_TOKEN_LEN - 3'd1);
        end
        else
        begin
            token_idx_next = (s_tdata == CHAR_UP_H) ? 3'd1 : 3'd0;
        end
        byte_count_next = (byte_count_reg == 6'd63) ? byte_count_reg : byte_count_reg + 6'd1;
    end

    always_comb
    begin
        for (int k = 0; k < HOST_MAX; k++)
        begin
            window_next[k] = (win_write && bat_reg[WIN_IDX_W-1:0] == WIN_IDX_W'(k))
                             ? s_tdata : window_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg      <= METHOD_WAIT;
            byte_count_reg  <= '0;
            token_idx_reg   <= '0;
            token_found_reg <= 1'b0;
            stopped_reg     <= 1'b0;
            bat_reg         <= '0;
        end
        else if (last_fire)
        begin
            method_reg      <= METHOD_WAIT;
            byte_count_reg  <= '0;
            token_idx_reg   <= '0;
            token_found_reg <= 1'b0;
            stopped_reg     <= 1'b0;
            bat_reg         <= '0;
        end
        else if (in_fire)
        begin
            method_reg      <= method_next;
            byte_count_reg  <= byte_count_next;
            token_idx_reg   <= token_idx_next;
            token_found_reg <= token_found_next;
            stopped_reg     <= stopped_next;
            bat_reg         <= bat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int k = 0; k < HOST_MAX; k++)
            begin
                window_reg[k] <= window_next[k];
            end
        end
    end

    always_comb
    begin
        s1_host_next = 1'b0;
        if (byte_count_next < MIN_PAYLOAD_C)
        begin
            s1_reason_next = REASON_SHORT;
        end
        else if (!method_ok)
        begin
            s1_reason_next = REASON_NO_METHOD;
        end
        else if (!token_found_next)
        begin
            s1_reason_next = REASON_NO_HOST;
        end
        else
        begin
            s1_reason_next = REASON_HOST_MISS;
            s1_host_next   = 1'b1;
        end
        if ({1'b0, bat_next} >= HOST_MAX_C)
        begin
            s1_wlen_next = WLEN_W'(HOST_MAX);
        end
        else
        begin
            s1_wlen_next = WLEN_W'(bat_next);
        end
        s1_valid_next = last_fire ? 1'b1 : (s2_free ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (last_fire)
        begin
            s1_reason_reg <= s1_reason_next;
            s1_host_reg   <= s1_host_next;
            s1_wlen_reg   <= s1_wlen_next;
            for (int k = 0; k < HOST_MAX; k++)
            begin
                s1_window_reg[k] <= window_next[k];
            end
        end
    end

    // A pattern byte counts while it lies below the configured length and no zero byte lies at or before it.
    always_comb
    begin
        for (int i = 0; i < PAT_BYTES; i++)
        begin
            pat[i] = host_pattern_reg[i >> 3][(i & 7) * 8 +: 8];
        end
        for (int i = 0; i < PAT_BYTES; i++)
        begin
            pat_valid[i] = (6'(i) < host_length_reg);
            for (int j = 0; j <= i; j++)
            begin
                if (pat[j] == 8'h00)
                begin
                    pat_valid[i] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        s2_all_next = 1'b0;
        for (int i = 0; i + 2 < PAT_BYTES; i++)
        begin
            if (pat_valid[i + 2] && pat[i] == CHAR_UP_A && pat[i + 1] == CHAR_UP_L
                && pat[i + 2] == CHAR_UP_L)
            begin
                s2_all_next = 1'b1;
            end
        end
        s2_empty_next = !pat_valid[0];
        for (int s = 0; s < HOST_MAX; s++)
        begin
            s2_match_next[s] = 1'b1;
            for (int i = 0; i < PAT_BYTES; i++)
            begin
                if (pat_valid[i])
                begin
                    if (s + i >= HOST_MAX || (s + i) >= int'(s1_wlen_reg))
                    begin
                        s2_match_next[s] = 1'b0;
                    end
                    else if (s1_window_reg[(s + i) % HOST_MAX] != pat[i])
                    begin
                        s2_match_next[s] = 1'b0;
                    end
                end
            end
        end
        s2_reason_next = s1_reason_reg;
        s2_host_next   = s1_host_reg;
        s2_valid_next  = s1_to_s2 ? 1'b1 : (out_free ? 1'b0 : s2_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s1_to_s2)
        begin
            s2_reason_reg <= s2_reason_next;
            s2_host_reg   <= s2_host_next;
            s2_match_reg  <= s2_match_next;
            s2_all_reg    <= s2_all_next;
            s2_empty_reg  <= s2_empty_next;
        end
    end

    always_comb
    begin
        if (!s2_host_reg)
        begin
            out_reason_next  = s2_reason_reg;
            out_verdict_next = 1'b0;
        end
        else if (s2_all_reg)
        begin
            out_reason_next  = REASON_ALL;
            out_verdict_next = !invert_reg;
        end
        else if (s2_empty_reg || (|s2_match_reg))
        begin
            out_reason_next  = REASON_HOST_HIT;
            out_verdict_next = !invert_reg;
        end
        else
        begin
            out_reason_next  = REASON_HOST_MISS;
            out_verdict_next = invert_reg;
        end
        out_valid_next = s2_to_out ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s2_to_out)
        begin
            out_reason_reg  <= out_reason_next;
            out_verdict_reg <= out_verdict_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reason_reg, out_verdict_reg};

    `HHFM_ASSERT_SAME(a_stall_when_full, s1_valid_reg && !s2_free, !s_tready, "input taken while stage one is blocked")
    `HHFM_ASSERT_SAME(a_token_complete, token_found_reg, token_idx_reg == HOST_TOKEN_LEN, "header found without a full token")
    `HHFM_ASSERT_SAME(a_early_verdict_zero, m_tvalid && (out_reason_reg == REASON_SHORT || out_reason_reg == REASON_NO_METHOD || out_reason_reg == REASON_NO_HOST), !out_verdict_reg, "early failure with a set verdict")
    `HHFM_ASSERT_NEXT(a_packet_cleared, last_fire, byte_count_reg == 6'd0 && method_reg == METHOD_WAIT && !token_found_reg, "packet state not cleared after the last byte")

endmodule

`default_nettype wire
